/* rtl/ihss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihss_pkg
// Shared types, codes and signature tables for the image header size sniffer.
// ----------------------------------------------------------------------------
package ihss_pkg;

    // Default width of the byte position counter.
    localparam int POSITION_BITS_DEF = 32;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    // Format codes.
    localparam logic [1:0] FMT_PNG     = 2'd0;
    localparam logic [1:0] FMT_GIF     = 2'd1;
    localparam logic [1:0] FMT_JPEG    = 2'd2;
    localparam logic [1:0] FMT_UNKNOWN = 2'd3;

    // Record kinds.
    localparam logic KIND_DIMS    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Candidate bits in the magic match flags.
    localparam int CAND_PNG    = 0;
    localparam int CAND_GIF87  = 1;
    localparam int CAND_GIF89  = 2;
    localparam int CAND_JPEG   = 3;

    // JPEG marker bytes.
    localparam logic [7:0] MRK_PREFIX = 8'hFF;
    localparam logic [7:0] MRK_SOI    = 8'hD8;
    localparam logic [7:0] MRK_EOI    = 8'hD9;
    localparam logic [7:0] MRK_SOS    = 8'hDA;
    localparam logic [7:0] MRK_SOF0   = 8'hC0;
    localparam logic [7:0] MRK_SOF2   = 8'hC2;

    // GIF version digits.
    localparam logic [7:0] GIF_VER_7 = 8'h37;
    localparam logic [7:0] GIF_VER_9 = 8'h39;

    // Positions of interest in the file.
    localparam int MIN_FILE_LAST = 31;
    localparam int PNG_DIM_FIRST = 16;
    localparam int PNG_WID_LAST  = 19;
    localparam int PNG_DIM_LAST  = 23;
    localparam int GIF_DIM_FIRST = 6;
    localparam int GIF_DIM_LAST  = 9;
    localparam int MAGIC_LEN     = 8;
    localparam int GIF_MAGIC_LEN = 6;

    // JPEG walker phases.
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_WANT_FF = 7'b0000010,
        PH_MARKER  = 7'b0000100,
        PH_LEN_HI  = 7'b0001000,
        PH_LEN_LO  = 7'b0010000,
        PH_BODY    = 7'b0100000,
        PH_SCAN    = 7'b1000000
    } phase_t;

    // PNG signature byte at a given position.
    function automatic logic [7:0] png_sig(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd137;
            3'd1:    v = 8'd80;
            3'd2:    v = 8'd78;
            3'd3:    v = 8'd71;
            3'd4:    v = 8'd13;
            3'd5:    v = 8'd10;
            3'd6:    v = 8'd26;
            default: v = 8'd10;
        endcase
        return v;
    endfunction

    // GIF signature byte at a given position (the version digit is checked apart).
    function automatic logic [7:0] gif_sig(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h47;
            3'd1:    v = 8'h49;
            3'd2:    v = 8'h46;
            3'd3:    v = 8'h38;
            3'd4:    v = 8'h37;
            3'd5:    v = 8'h61;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* rtl/image_header_size_sniffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_size_sniffer
// Recognizes PNG, GIF and JPEG files from a byte stream, reports the image
// dimensions found in the header and a verdict on the last byte of each file.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                                  | tuser       | tlast
//  s_      | in        | [7:0] data_byte                        | -           | end_of_file
//  m_      | out       | width, height, format, status (72 bit) | record_kind | -
//
//  Each byte passes an input register and then combinational parsing logic
//  into the result register, so a transaction is taken every cycle while
//  parsing does not stall, and a result is loaded into the result register
//  when its byte advances out of the input register.
//  A waiting result does not block input: parsing stalls only when a held
//  result is not taken and the registered byte would produce a new one.
//  Reset (aresetn low, synchronous) clears valid flags and parser state;
//  after each verdict the parser returns to its reset state for the next file.
// ----------------------------------------------------------------------------
module image_header_size_sniffer
    import ihss_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input bytes.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_file
    // Result records.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] width, [63:32] height,
                                            // [65:64] format, [66] status,
                                            // [71:67] zero
    output logic                 m_tuser    // record_kind
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state.
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [3:0]  flags_reg, flags_next;
    phase_t      phase_reg, phase_next;
    logic [16:0] seg_off_reg, seg_off_next;
    logic [15:0] seg_len_reg, seg_len_next;
    logic [7:0]  marker_reg, marker_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [7:0]  prev_reg, prev_next;
    logic        err_reg, err_next;
    logic        scan_reg, scan_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [31:0] out_width_reg, out_width_next;
    logic [31:0] out_height_reg, out_height_next;
    logic [1:0]  out_fmt_reg, out_fmt_next;
    logic        out_status_reg, out_status_next;

    // Handshake and advance.
    logic advance;
    logic emit;

    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_fmt_reg, out_height_reg, out_width_reg};

    // Parse the registered byte.
    always_comb begin
        logic [7:0]  b;
        logic [2:0]  p;
        logic        dims;
        logic        sof;
        logic        bad;
        logic [15:0] len_v;
        logic [16:0] off_v;

        b     = in_byte_reg;
        p     = pos_reg[2:0];
        dims  = 1'b0;
        bad   = 1'b0;
        emit  = 1'b0;
        sof   = (marker_reg == MRK_SOF0) || (marker_reg == MRK_SOF2);
        len_v = {seg_len_reg[15:8], b};
        off_v = seg_off_reg + 17'd1;

        pos_next     = pos_reg;
        fmt_next     = fmt_reg;
        flags_next   = flags_reg;
        phase_next   = phase_reg;
        seg_off_next = seg_off_reg;
        seg_len_next = seg_len_reg;
        marker_next  = marker_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        err_next     = err_reg;
        scan_next    = scan_reg;

        out_kind_next   = out_kind_reg;
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        out_fmt_next    = out_fmt_reg;
        out_status_next = out_status_reg;

        if (!err_reg) begin
            // Magic bytes at the start of the file.
            if (pos_reg < POSITION_BITS'(MAGIC_LEN)) begin
                if (b != png_sig(p)) flags_next[CAND_PNG] = 1'b0;
                if (pos_reg < POSITION_BITS'(GIF_MAGIC_LEN)) begin
                    if (p == 3'd4) begin
                        if (b != GIF_VER_7) flags_next[CAND_GIF87] = 1'b0;
                        if (b != GIF_VER_9) flags_next[CAND_GIF89] = 1'b0;
                    end else if (b != gif_sig(p)) begin
                        flags_next[CAND_GIF87] = 1'b0;
                        flags_next[CAND_GIF89] = 1'b0;
                    end
                end
                if (p == 3'd0 && b != MRK_PREFIX) flags_next[CAND_JPEG] = 1'b0;
                if (p == 3'd1 && b != MRK_SOI) flags_next[CAND_JPEG] = 1'b0;

                if (p == 3'd1 && flags_next[CAND_JPEG]) begin
                    fmt_next   = FMT_JPEG;
                    phase_next = PH_WANT_FF;
                end
                if (p == 3'd5 && (flags_next[CAND_GIF87] || flags_next[CAND_GIF89])) begin
                    fmt_next = FMT_GIF;
                end
                if (p == 3'd7 && flags_next[CAND_PNG]) fmt_next = FMT_PNG;
                if (fmt_next == FMT_UNKNOWN && flags_next == 4'd0) err_next = 1'b1;
            end

            // Header fields for the recognized format.
            if (!err_next) begin
                if (fmt_next == FMT_PNG && pos_reg >= POSITION_BITS'(PNG_DIM_FIRST)
                        && pos_reg <= POSITION_BITS'(PNG_DIM_LAST)) begin
                    if (pos_reg <= POSITION_BITS'(PNG_WID_LAST)) begin
                        width_next = {width_reg[23:0], b};
                    end else begin
                        height_next = {height_reg[23:0], b};
                    end
                    dims = (pos_reg == POSITION_BITS'(PNG_DIM_LAST));
                end else if (fmt_next == FMT_GIF && pos_reg >= POSITION_BITS'(GIF_DIM_FIRST)
                        && pos_reg <= POSITION_BITS'(GIF_DIM_LAST)) begin
                    case (pos_reg[1:0])
                        2'd2:    width_next  = {24'd0, b};
                        2'd3:    width_next  = {16'd0, b, width_reg[7:0]};
                        2'd0:    height_next = {24'd0, b};
                        default: height_next = {16'd0, b, height_reg[7:0]};
                    endcase
                    dims = (pos_reg == POSITION_BITS'(GIF_DIM_LAST));
                end else if (fmt_next == FMT_JPEG && pos_reg >= POSITION_BITS'(2)) begin
                    // JPEG marker segment walk.
                    case (phase_reg)
                        PH_WANT_FF: begin
                            if (b != MRK_PREFIX) err_next = 1'b1;
                            else phase_next = PH_MARKER;
                        end
                        PH_MARKER: begin
                            marker_next = b;
                            if (b == MRK_SOS) begin
                                scan_next  = 1'b1;
                                phase_next = PH_SCAN;
                            end else begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                        PH_LEN_HI: begin
                            seg_len_next = {b, 8'd0};
                            phase_next   = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            seg_len_next = len_v;
                            if (len_v < 16'd2 || (sof && len_v < 16'd7)) begin
                                err_next = 1'b1;
                            end else begin
                                seg_off_next = 17'd4;
                                phase_next   = (len_v == 16'd2) ? PH_WANT_FF : PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            if (sof) begin
                                if (seg_off_reg == 17'd5 || seg_off_reg == 17'd6) begin
                                    height_next = {16'd0, height_reg[7:0], b};
                                end
                                if (seg_off_reg == 17'd7 || seg_off_reg == 17'd8) begin
                                    width_next = {16'd0, width_reg[7:0], b};
                                end
                                dims = (seg_off_reg == 17'd8);
                            end
                            seg_off_next = off_v;
                            if (off_v >= {1'b0, seg_len_reg} + 17'd2) phase_next = PH_WANT_FF;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        prev_next = b;
        if (pos_reg != POS_MAX) pos_next = pos_reg + POSITION_BITS'(1);

        // Verdict on the last byte, or a dimension record.
        if (in_last_reg) begin
            bad = err_next || pos_reg < POSITION_BITS'(MIN_FILE_LAST)
                || fmt_next == FMT_UNKNOWN;
            if (fmt_next == FMT_JPEG) begin
                if ({prev_reg, b} != {MRK_PREFIX, MRK_EOI}) bad = 1'b1;
                if (!scan_next && phase_next != PH_WANT_FF) bad = 1'b1;
                if (dims) bad = 1'b1;
            end
            emit            = 1'b1;
            out_kind_next   = KIND_VERDICT;
            out_width_next  = 32'd0;
            out_height_next = 32'd0;
            out_fmt_next    = fmt_next;
            out_status_next = bad;

            // Back to the reset state for the next file.
            pos_next     = '0;
            fmt_next     = FMT_UNKNOWN;
            flags_next   = 4'hF;
            phase_next   = PH_HEADER;
            seg_off_next = 17'd0;
            seg_len_next = 16'd0;
            marker_next  = 8'd0;
            width_next   = 32'd0;
            height_next  = 32'd0;
            prev_next    = 8'd0;
            err_next     = 1'b0;
            scan_next    = 1'b0;
        end else if (dims) begin
            emit            = 1'b1;
            out_kind_next   = KIND_DIMS;
            out_width_next  = width_next;
            out_height_next = height_next;
            out_fmt_next    = fmt_next;
            out_status_next = 1'b0;
        end
    end

    // Valid flags of the input and result registers.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        if (advance && emit) out_valid_next = 1'b1;
    end

    // Control and parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            fmt_reg       <= FMT_UNKNOWN;
            flags_reg     <= 4'hF;
            phase_reg     <= PH_HEADER;
            seg_off_reg   <= 17'd0;
            seg_len_reg   <= 16'd0;
            marker_reg    <= 8'd0;
            width_reg     <= 32'd0;
            height_reg    <= 32'd0;
            prev_reg      <= 8'd0;
            err_reg       <= 1'b0;
            scan_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pos_reg     <= pos_next;
                fmt_reg     <= fmt_next;
                flags_reg   <= flags_next;
                phase_reg   <= phase_next;
                seg_off_reg <= seg_off_next;
                seg_len_reg <= seg_len_next;
                marker_reg  <= marker_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                prev_reg    <= prev_next;
                err_reg     <= err_next;
                scan_reg    <= scan_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && emit) begin
            out_kind_reg   <= out_kind_next;
            out_width_reg  <= out_width_next;
            out_height_reg <= out_height_next;
            out_fmt_reg    <= out_fmt_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

/* dv/image_header_size_sniffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_size_sniffer_tb
// Streams whole PNG, GIF, JPEG and garbage files through the sniffer, one byte
// per transaction, with bursty input and a stalling result sink. A predictor
// in the bench tracks the parse of each file and queues the dimension and
// verdict records that the accepted bytes should produce; the monitor checks
// each result record against the oldest one queued.
// ----------------------------------------------------------------------------
module image_header_size_sniffer_tb;
    import ihss_pkg::*;

    // File signatures, first byte in the top bits.
    localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
    localparam logic [47:0] GIF_MAGIC = 48'h474946383761;
    // The JPEG segment walk starts after the start-of-image marker.
    localparam int JPEG_WALK_FIRST = 2;
    // Offsets of height and width inside an SOF segment, counted from its FF prefix.
    localparam int SOF_HGT_HI = 5;
    localparam int SOF_HGT_LO = 6;
    localparam int SOF_WID_HI = 7;
    localparam int SOF_WID_LO = 8;
    localparam int RANDOM_BYTES = 1390;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] width;
        logic [31:0] height;
        logic [1:0]  fmt;
        logic        status;
    } record_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    image_header_size_sniffer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    file_byte_t byte_backlog[$];
    record_t    due_records[$];
    logic [7:0] file_bytes[$];
    int         bytes_queued = 0;
    int         mismatches = 0;

    // ------------------------------------------------------------------------
    // Header parse predictor
    // ------------------------------------------------------------------------
    logic [POSITION_BITS_DEF-1:0] p_pos;
    logic [1:0]  p_fmt;
    logic [3:0]  p_cand;
    phase_t      p_phase;
    logic [31:0] p_seg_off;
    logic [16:0] p_seg_len;
    logic [7:0]  p_marker;
    logic [31:0] p_wid;
    logic [31:0] p_hgt;
    logic [15:0] p_tail;
    logic        p_err;
    logic        p_scan;

    function automatic void clear_sniffer();
        p_pos     = '0;
        p_fmt     = FMT_UNKNOWN;
        p_cand    = 4'hF;
        p_phase   = PH_HEADER;
        p_seg_off = '0;
        p_seg_len = '0;
        p_marker  = '0;
        p_wid     = '0;
        p_hgt     = '0;
        p_tail    = '0;
        p_err     = 1'b0;
        p_scan    = 1'b0;
    endfunction

    // Drop every candidate whose signature disagrees with this byte; set the format when a signature completes.
    function automatic void match_magic(input int pos, input logic [7:0] b);
        if (b != PNG_MAGIC[63-8*pos -: 8]) p_cand[CAND_PNG] = 1'b0;
        if (pos < GIF_MAGIC_LEN) begin
            if (pos == 4) begin
                if (b != GIF_VER_7) p_cand[CAND_GIF87] = 1'b0;
                if (b != GIF_VER_9) p_cand[CAND_GIF89] = 1'b0;
            end else if (b != GIF_MAGIC[47-8*pos -: 8]) begin
                p_cand[CAND_GIF87] = 1'b0;
                p_cand[CAND_GIF89] = 1'b0;
            end
        end
        if (pos == 0 && b != MRK_PREFIX) p_cand[CAND_JPEG] = 1'b0;
        if (pos == 1 && b != MRK_SOI) p_cand[CAND_JPEG] = 1'b0;
        if (pos == 1 && p_cand[CAND_JPEG]) begin
            p_fmt   = FMT_JPEG;
            p_phase = PH_WANT_FF;
        end
        if (pos == GIF_MAGIC_LEN - 1 && (p_cand[CAND_GIF87] || p_cand[CAND_GIF89]))
            p_fmt = FMT_GIF;
        if (pos == MAGIC_LEN - 1 && p_cand[CAND_PNG]) p_fmt = FMT_PNG;
        if (p_fmt == FMT_UNKNOWN && p_cand == 4'h0) p_err = 1'b1;
    endfunction

    // One step of the JPEG marker walk; true when an SOF size completes.
    function automatic bit walk_jpeg(input logic [7:0] b);
        bit sof;
        bit done;
        sof  = (p_marker == MRK_SOF0 || p_marker == MRK_SOF2);
        done = 1'b0;
        case (p_phase)
            PH_WANT_FF: begin
                if (b != MRK_PREFIX) p_err = 1'b1;
                else p_phase = PH_MARKER;
            end
            PH_MARKER: begin
                p_marker = b;
                if (b == MRK_SOS) begin
                    p_scan  = 1'b1;
                    p_phase = PH_SCAN;
                end else begin
                    p_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                p_seg_len = {1'b0, b, 8'h00};
                p_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                p_seg_len[7:0] = b;
                if (p_seg_len < 2 || (sof && p_seg_len < 7)) begin
                    p_err = 1'b1;
                end else begin
                    p_seg_off = 4;
                    p_phase   = (p_seg_len == 2) ? PH_WANT_FF : PH_BODY;
                end
            end
            PH_BODY: begin
                if (sof) begin
                    if (p_seg_off == SOF_HGT_HI || p_seg_off == SOF_HGT_LO)
                        p_hgt = {16'h0000, p_hgt[7:0], b};
                    if (p_seg_off == SOF_WID_HI || p_seg_off == SOF_WID_LO)
                        p_wid = {16'h0000, p_wid[7:0], b};
                    done = (p_seg_off == SOF_WID_LO);
                end
                p_seg_off = p_seg_off + 1;
                if (p_seg_off >= p_seg_len + 2) p_phase = PH_WANT_FF;
            end
            default: ;
        endcase
        return done;
    endfunction

    // Advance the predictor by one accepted byte; true when a record is due.
    function automatic bit sniff_byte(input logic [7:0] b, input logic last,
                                      output record_t rec);
        logic [31:0] pos;
        bit          dims;
        bit          bad;
        pos  = p_pos;
        dims = 1'b0;
        rec  = '0;
        if (!p_err) begin
            if (pos < MAGIC_LEN) match_magic(pos, b);
            if (!p_err) begin
                if (p_fmt == FMT_PNG && pos >= PNG_DIM_FIRST && pos <= PNG_DIM_LAST) begin
                    if (pos <= PNG_WID_LAST) p_wid = {p_wid[23:0], b};
                    else p_hgt = {p_hgt[23:0], b};
                    dims = (pos == PNG_DIM_LAST);
                end else if (p_fmt == FMT_GIF && pos >= GIF_DIM_FIRST
                             && pos <= GIF_DIM_LAST) begin
                    if (pos == GIF_DIM_FIRST) p_wid = {24'h0, b};
                    if (pos == GIF_DIM_FIRST + 1) p_wid[15:8] = b;
                    if (pos == GIF_DIM_FIRST + 2) p_hgt = {24'h0, b};
                    if (pos == GIF_DIM_LAST) p_hgt[15:8] = b;
                    dims = (pos == GIF_DIM_LAST);
                end else if (p_fmt == FMT_JPEG && pos >= JPEG_WALK_FIRST) begin
                    dims = walk_jpeg(b);
                end
            end
        end
        p_tail = {p_tail[7:0], b};
        if (p_pos != '1) p_pos = p_pos + 1;

        // The last byte always closes the file with a verdict.
        if (last) begin
            bad = p_err || pos < MIN_FILE_LAST || p_fmt == FMT_UNKNOWN;
            if (p_fmt == FMT_JPEG) begin
                if (p_tail != {MRK_PREFIX, MRK_EOI}) bad = 1'b1;
                if (!p_scan && p_phase != PH_WANT_FF) bad = 1'b1;
                if (dims) bad = 1'b1;
            end
            rec.kind   = KIND_VERDICT;
            rec.fmt    = p_fmt;
            rec.status = bad;
            clear_sniffer();
            return 1'b1;
        end
        if (dims) begin
            rec = {KIND_DIMS, p_wid, p_hgt, p_fmt, 1'b0};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] v);
        file_bytes.insert(file_bytes.size(), v);
    endtask

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic put_rand(input int n);
        for (int i = 0; i < n; i++) add_byte(rand_byte());
    endtask

    task automatic pad_to(input int n);
        while (file_bytes.size() < n) add_byte(rand_byte());
    endtask

    task automatic trim_to(input int n);
        while (file_bytes.size() > n) file_bytes.delete(file_bytes.size() - 1);
    endtask

    task automatic build_png(input logic [31:0] w, input logic [31:0] h);
        for (int i = 0; i < MAGIC_LEN; i++) add_byte(PNG_MAGIC[63-8*i -: 8]);
        put_rand(8);
        for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
        for (int i = 3; i >= 0; i--) add_byte(h[8*i +: 8]);
    endtask

    task automatic build_gif(input bit ver89, input logic [15:0] w, input logic [15:0] h);
        for (int i = 0; i < GIF_MAGIC_LEN; i++) begin
            if (i == 4) add_byte(ver89 ? GIF_VER_9 : GIF_VER_7);
            else add_byte(GIF_MAGIC[47-8*i -: 8]);
        end
        add_byte(w[7:0]);
        add_byte(w[15:8]);
        add_byte(h[7:0]);
        add_byte(h[15:8]);
    endtask

    // A marker segment whose body starts with the given head bytes.
    task automatic jpeg_segment(input logic [7:0] mk, input logic [15:0] len,
                                input logic [39:0] head);
        int body;
        body = len;
        body = body - 2;
        add_byte(MRK_PREFIX);
        add_byte(mk);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        for (int i = 0; i < body; i++)
            add_byte(i < 5 ? head[39-8*i -: 8] : rand_byte());
    endtask

    task automatic jpeg_sof(input logic [7:0] mk, input logic [15:0] h,
                            input logic [15:0] w, input logic [15:0] len);
        jpeg_segment(mk, len, {rand_byte(), h, w});
    endtask

    task automatic jpeg_tail(input int scan_len);
        add_byte(MRK_PREFIX);
        add_byte(MRK_SOS);
        put_rand(scan_len);
        add_byte(MRK_PREFIX);
        add_byte(MRK_EOI);
    endtask

    task automatic jpeg_start();
        add_byte(MRK_PREFIX);
        add_byte(MRK_SOI);
    endtask

    // Move the file under construction to the input backlog.
    task automatic ship_file();
        file_byte_t fb;
        for (int i = 0; i < file_bytes.size(); i++) begin
            fb.data = file_bytes[i];
            fb.last = (i == file_bytes.size() - 1);
            byte_backlog.insert(byte_backlog.size(), fb);
        end
        bytes_queued += file_bytes.size();
        file_bytes.delete();
    endtask

    // A well-formed JPEG with random segments, ending in a scan and trailer.
    task automatic build_jpeg_random();
        logic [7:0] mk;
        int         nseg;
        int         scan_len;
        jpeg_start();
        nseg = $urandom_range(0, 4);
        for (int s = 0; s < nseg; s++) begin
            if ($urandom_range(0, 2) == 0) begin
                jpeg_sof($urandom_range(0, 1) ? MRK_SOF2 : MRK_SOF0, rand_byte() << 8 | 16'(rand_byte()),
                         {rand_byte(), rand_byte()}, 16'($urandom_range(7, 14)));
            end else begin
                do mk = rand_byte();
                while (mk == MRK_SOS || mk == MRK_SOF0 || mk == MRK_SOF2);
                jpeg_segment(mk, 16'($urandom_range(2, 12)), {rand_byte(), 32'($urandom)});
            end
        end
        scan_len = $urandom_range(0, 20);
        if (file_bytes.size() + scan_len + 4 < 32) scan_len = 28 - file_bytes.size();
        jpeg_tail(scan_len);
    endtask

    // One random file, mostly well-formed, sometimes damaged or pure noise.
    task automatic random_file();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            build_png($urandom, $urandom);
            pad_to($urandom_range(32, 48));
        end else if (pick < 45) begin
            build_gif($urandom_range(0, 1), {rand_byte(), rand_byte()}, {rand_byte(), rand_byte()});
            pad_to($urandom_range(32, 44));
        end else if (pick < 88) begin
            build_jpeg_random();
        end else begin
            if ($urandom_range(0, 1)) jpeg_start();
            put_rand($urandom_range(1, 50));
        end
        // Damage about a quarter of the files.
        n = file_bytes.size();
        case ($urandom_range(0, 11))
            0: file_bytes[$urandom_range(0, n - 1)] = rand_byte();
            1: trim_to($urandom_range(1, n));
            2: file_bytes[$urandom_range(0, n < 8 ? n - 1 : 7)] = rand_byte();
            default: ;
        endcase
        ship_file();
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin : feeder
        record_t    rec;
        file_byte_t dropped;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (sniff_byte(s_tdata, s_tlast, rec))
                    due_records.insert(due_records.size(), rec);
                dropped = byte_backlog.pop_front();
            end
            if (gap_left > 0 || byte_backlog.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_backlog[0].data;
                s_tlast  <= byte_backlog[0].last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = $urandom_range(1, 8);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: ready pattern changes mode at the end of each random window of cycles
    // ------------------------------------------------------------------------
    int sink_mode = 0;
    int sink_window = 0;
    int sink_tick = 0;

    always @(posedge aclk) begin : sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (sink_window == 0) begin
                sink_mode   = $urandom_range(0, 3);
                sink_window = $urandom_range(20, 120);
            end else begin
                sink_window--;
            end
            sink_tick++;
            case (sink_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= (sink_tick % 4) != 0;
                default: m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : monitor
        record_t got;
        record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[65:64], m_tdata[66]};
            if (due_records.size() == 0) begin
                note_mismatch($sformatf("unexpected record kind %0d w %h h %h fmt %0d st %0d",
                              got.kind, got.width, got.height, got.fmt, got.status));
            end else begin
                want = due_records.pop_front();
                if (got.kind !== want.kind || got.width !== want.width
                    || got.height !== want.height || got.fmt !== want.fmt
                    || got.status !== want.status || m_tdata[71:67] !== 5'd0)
                    note_mismatch($sformatf(
                        "exp kind %0d w %h h %h fmt %0d st %0d, got kind %0d w %h h %h fmt %0d st %0d pad %h",
                        want.kind, want.width, want.height, want.fmt, want.status,
                        got.kind, got.width, got.height, got.fmt, got.status, m_tdata[71:67]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int random_base;
        clear_sniffer();

        // Extreme PNG and GIF sizes, both GIF versions.
        build_png(32'hFFFFFFFF, 32'hFFFFFFFF);
        pad_to(32);
        ship_file();
        build_png(32'h0, 32'h0);
        pad_to(33);
        ship_file();
        build_gif(1'b0, 16'hFFFF, 16'h0000);
        pad_to(32);
        ship_file();
        build_gif(1'b1, 16'h0000, 16'hFFFF);
        pad_to(40);
        ship_file();
        // Good JPEG: empty segment, then both SOF kinds at the size extremes.
        jpeg_start();
        jpeg_segment(8'hE0, 16'd2, 40'h0);
        jpeg_sof(MRK_SOF0, 16'hFFFF, 16'h0001, 16'd17);
        jpeg_sof(MRK_SOF2, 16'h0000, 16'hFFFF, 16'd7);
        jpeg_tail(4);
        ship_file();
        // Short file that still carries a PNG size.
        build_png($urandom, $urandom);
        pad_to(31);
        ship_file();
        // No signature matches.
        add_byte(8'h00);
        put_rand(39);
        ship_file();
        // JPEG segment without its FF prefix.
        jpeg_start();
        add_byte(8'h00);
        pad_to(40);
        ship_file();
        // Segment lengths of one and zero.
        jpeg_start();
        jpeg_segment(8'hE1, 16'd1, 40'h0);
        pad_to(38);
        jpeg_tail(0);
        ship_file();
        jpeg_start();
        jpeg_segment(8'hE2, 16'd0, 40'h0);
        pad_to(38);
        jpeg_tail(0);
        ship_file();
        // SOF length too small to hold a size.
        jpeg_start();
        jpeg_sof(MRK_SOF0, 16'h1234, 16'h5678, 16'd6);
        pad_to(38);
        jpeg_tail(0);
        ship_file();
        // File ends inside a comment segment, although on FF D9.
        jpeg_start();
        jpeg_segment(8'hFE, 16'd40, 40'h0);
        trim_to(34);
        add_byte(MRK_PREFIX);
        add_byte(MRK_EOI);
        ship_file();
        // SOF width completes on the final byte.
        jpeg_start();
        jpeg_segment(8'hE0, 16'd24, 40'h0);
        jpeg_sof(MRK_SOF0, 16'hABCD, 16'h4321, 16'd17);
        trim_to(37);
        ship_file();
        // Complete walk but the trailer is not FF D9.
        jpeg_start();
        jpeg_sof(MRK_SOF2, 16'h0100, 16'h0080, 16'd11);
        jpeg_tail(20);
        file_bytes[file_bytes.size() - 1] = MRK_SOI;
        ship_file();
        // FF D9 reached as a segment marker, before any scan.
        jpeg_start();
        jpeg_segment(8'hFE, 16'd30, 40'h0);
        add_byte(MRK_PREFIX);
        add_byte(MRK_EOI);
        ship_file();
        // One-byte file.
        add_byte(8'h89);
        ship_file();

        random_base = bytes_queued;
        while (bytes_queued - random_base < RANDOM_BYTES) random_file();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (due_records.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && due_records.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
